// File: sv/spq_pkg.sv
package spq_pkg;

    // Number of entries the queue can hold.
    localparam int CAPACITY = 16;

    // Occupancy must be able to hold the capacity itself.
    localparam int OCC_W = $clog2(CAPACITY + 1);

    // Width of the count field carried in each result.
    localparam int COUNT_W = 5;

    // Operation codes carried in the kind field.
    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    // One command beat.
    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] value;
    } cmd_t;

    // One result beat.
    typedef struct packed {
        logic signed [31:0]  removed_value;
        logic                removed_valid;
        logic                underflow;
        logic                overflow;
        logic [COUNT_W-1:0]  count;
    } result_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic               shift_in;
        logic               shift_out;
        logic signed [31:0] key;
    } cell_ctrl_t;

endpackage

// File: sv/spq_cell.sv
module spq_cell (
    input  logic                      clk,
    input  spq_pkg::cell_ctrl_t       ctrl,
    input  logic                      occupied,
    input  logic                      left_greater,
    input  logic signed [31:0]        left_value,
    input  logic signed [31:0]        right_value,
    output logic                      greater,
    output logic signed [31:0]        value
);
    import spq_pkg::*;

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    // This entry stays ahead of the new key when it is held and strictly larger.
    assign greater = occupied && (value_reg > ctrl.key);
    assign value   = value_reg;

    // On an insert an entry either stays, takes the key, or takes its left
    // neighbour; on a removal every entry moves one place towards the head.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift_in)
        begin
            if (greater)
            begin
                value_next = value_reg;
            end
            else if (left_greater)
            begin
                value_next = ctrl.key;
            end
            else
            begin
                value_next = left_value;
            end
        end
        else if (ctrl.shift_out)
        begin
            value_next = right_value;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: sv/sorted_max_priority_queue.sv
// Channel   Direction  Handshake        Payload
// command   in         start / busy     cmd    (kind, value)
// result    out        done strobe      result (removed_value, removed_valid,
//                                               underflow, overflow, count)
//
// No command stalls: all cells of the chain compare against the
// key and move on the same clock edge, so busy never rises.
// The result beat appears on the cycle after the command beat, for one cycle.
// Reset clears the occupancy and the result strobe; entry storage is left as is.
// The receiver cannot stall, so results are never held back.
module sorted_max_priority_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::cmd_t     cmd,
    output logic              done,
    output spq_pkg::result_t  result
);
    import spq_pkg::*;

    logic [OCC_W-1:0]   occupancy_reg;
    logic [OCC_W-1:0]   occupancy_next;
    logic               done_reg;
    logic               done_next;
    result_t            result_reg;
    result_t            result_next;

    cell_ctrl_t         ctrl;
    logic               accept;
    logic               is_full;
    logic               is_empty;
    logic               occupied [CAPACITY];
    logic               greater  [CAPACITY];
    logic signed [31:0] values   [CAPACITY];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (occupancy_reg == OCC_W'(CAPACITY));
    assign is_empty = (occupancy_reg == '0);

    // Control broadcast to the chain.
    assign ctrl.shift_in  = accept && (cmd.kind == KIND_INSERT) && !is_full;
    assign ctrl.shift_out = accept && (cmd.kind == KIND_REMOVE) && !is_empty;
    assign ctrl.key       = cmd.value;

    // The chain of cells, head at index zero.
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            assign occupied[i] = (OCC_W'(i) < occupancy_reg);

            if (i == 0)
            begin : g_head
                spq_cell u_cell (
                    .clk          (clk),
                    .ctrl         (ctrl),
                    .occupied     (occupied[i]),
                    .left_greater (1'b1),
                    .left_value   (ctrl.key),
                    .right_value  (values[i+1]),
                    .greater      (greater[i]),
                    .value        (values[i])
                );
            end
            else if (i == CAPACITY - 1)
            begin : g_tail
                spq_cell u_cell (
                    .clk          (clk),
                    .ctrl         (ctrl),
                    .occupied     (occupied[i]),
                    .left_greater (greater[i-1]),
                    .left_value   (values[i-1]),
                    .right_value  (32'sd0),
                    .greater      (greater[i]),
                    .value        (values[i])
                );
            end
            else
            begin : g_body
                spq_cell u_cell (
                    .clk          (clk),
                    .ctrl         (ctrl),
                    .occupied     (occupied[i]),
                    .left_greater (greater[i-1]),
                    .left_value   (values[i-1]),
                    .right_value  (values[i+1]),
                    .greater      (greater[i]),
                    .value        (values[i])
                );
            end
        end
    endgenerate

    // Occupancy follows the accepted operation.
    always_comb
    begin
        occupancy_next = occupancy_reg;
        if (ctrl.shift_in)
        begin
            occupancy_next = occupancy_reg + OCC_W'(1);
        end
        else if (ctrl.shift_out)
        begin
            occupancy_next = occupancy_reg - OCC_W'(1);
        end
    end

    // Result beat built from the state before the update; its count is the occupancy after it.
    always_comb
    begin
        done_next                 = accept;
        result_next.removed_value = ctrl.shift_out ? values[0] : 32'sd0;
        result_next.removed_valid = ctrl.shift_out;
        result_next.underflow     = (cmd.kind == KIND_REMOVE) && is_empty;
        result_next.overflow      = (cmd.kind == KIND_INSERT) && is_full;
        result_next.count         = COUNT_W'(occupancy_next);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            occupancy_reg <= occupancy_next;
            done_reg      <= done_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every command beat gives a result beat on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("command beat not answered");

    // An overflow only happens with a full queue, which it leaves full.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |-> (occupancy_reg == OCC_W'(CAPACITY)))
        else $error("overflow reported on a queue that is not full");

    // An underflow only happens with an empty queue, and removes nothing.
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.underflow) |-> (occupancy_reg == '0 && !result.removed_valid))
        else $error("underflow reported on a queue that holds entries");

    // Occupancy never passes the capacity.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

endmodule

// File: tb/sv/spq_outcome_checker.sv
module spq_outcome_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  spq_pkg::cmd_t    cmd,
    input  logic             done,
    input  spq_pkg::result_t result,
    output int               failures,
    output int               pending
);
    import spq_pkg::*;

    // Shadow copy of the queue contents, largest value first.
    logic signed [31:0] mirror_entries [CAPACITY];
    int                 mirror_count;

    // Outcomes still owed by the block, oldest first.
    result_t            outcome_fifo [$];
    result_t            oldest;
    int                 beat_errors;

    // Apply one command beat to the shadow queue and return the answer it must give.
    function automatic result_t queue_outcome(input cmd_t c);
        result_t r;
        int      pos;
        r = '0;
        if (c.kind == KIND_INSERT)
        begin
            if (mirror_count >= CAPACITY)
            begin
                r.overflow = 1'b1;
            end
            else
            begin
                // A new value goes after every strictly larger entry.
                pos = 0;
                while (pos < mirror_count && mirror_entries[pos] > $signed(c.value))
                    pos++;
                for (int i = mirror_count; i > pos; i--)
                    mirror_entries[i] = mirror_entries[i-1];
                mirror_entries[pos] = $signed(c.value);
                mirror_count++;
            end
        end
        else
        begin
            if (mirror_count == 0)
            begin
                r.underflow = 1'b1;
            end
            else
            begin
                r.removed_value = mirror_entries[0];
                r.removed_valid = 1'b1;
                for (int i = 1; i < mirror_count; i++)
                    mirror_entries[i-1] = mirror_entries[i];
                mirror_count--;
            end
        end
        // Only the low bits of the occupancy are reported.
        r.count = COUNT_W'(mirror_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_count = 0;
            outcome_fifo.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            beat_errors = 0;

            // A command beat is taken: record what the queue has to answer.
            if (start && !busy)
                outcome_fifo.push_back(queue_outcome(cmd));

            // A result beat: compare it with the oldest outstanding answer.
            if ($isunknown(done))
            begin
                $error("done: expected a known level, got %b", done);
                beat_errors++;
            end
            else if (done)
            begin
                if (outcome_fifo.size() == 0)
                begin
                    $error("result beat arrived with no command outstanding");
                    beat_errors++;
                end
                else
                begin
                    oldest = outcome_fifo.pop_front();
                    if (result.removed_value !== oldest.removed_value)
                    begin
                        $error("removed_value: expected %0d, got %0d",
                               oldest.removed_value, result.removed_value);
                        beat_errors++;
                    end
                    if (result.removed_valid !== oldest.removed_valid)
                    begin
                        $error("removed_valid: expected %b, got %b",
                               oldest.removed_valid, result.removed_valid);
                        beat_errors++;
                    end
                    if (result.underflow !== oldest.underflow)
                    begin
                        $error("underflow: expected %b, got %b",
                               oldest.underflow, result.underflow);
                        beat_errors++;
                    end
                    if (result.overflow !== oldest.overflow)
                    begin
                        $error("overflow: expected %b, got %b",
                               oldest.overflow, result.overflow);
                        beat_errors++;
                    end
                    if (result.count !== oldest.count)
                    begin
                        $error("count: expected %0d, got %0d",
                               oldest.count, result.count);
                        beat_errors++;
                    end
                end
            end

            failures <= failures + beat_errors;
            pending  <= outcome_fifo.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
module tb;

    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;
    int      failures;
    int      pending;
    int      cycle_count = 0;

    sorted_max_priority_queue i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    spq_outcome_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_max_priority_queue verification failed");
            $finish;
        end
    end

    // Present one command beat and hold it until the block takes it.
    task automatic issue_command(input kind_t k, input logic signed [31:0] v);
        cmd_t beat;
        beat.kind  = k;
        beat.value = v;
        start <= 1'b1;
        cmd   <= beat;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Leave the command channel idle for a random number of cycles.
    task automatic pause_sender(input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic drain_queue();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Values: full range, a narrow band that yields many ties, and the extremes.
    function automatic logic signed [31:0] random_value();
        logic signed [31:0] v;
        case ($urandom_range(3))
            0: v = $signed($urandom_range(8)) - 4;
            1:
            begin
                case ($urandom_range(3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Bursts lean towards inserting or removing, so the queue swings between
    // empty and full and both overflow and underflow are reached often.
    task automatic random_phase(input int beats, input int idle_pct);
        int    burst_left;
        int    insert_pct;
        kind_t k;
        burst_left = 0;
        insert_pct = 50;
        for (int n = 0; n < beats; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(40, 6);
                case ($urandom_range(2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            burst_left--;
            if ($urandom_range(99) < insert_pct)
                k = KIND_INSERT;
            else
                k = KIND_REMOVE;
            pause_sender(idle_pct);
            issue_command(k, random_value());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Removal from an empty queue, then a tie with the only entry.
        issue_command(KIND_REMOVE, 32'h1234_5678);
        issue_command(KIND_INSERT, 32'sd5);
        issue_command(KIND_INSERT, 32'sd5);

        // Extremes of the value range, zero and minus one.
        issue_command(KIND_INSERT, 32'h7FFF_FFFF);
        issue_command(KIND_INSERT, 32'h8000_0000);
        issue_command(KIND_INSERT, 32'h0000_0000);
        issue_command(KIND_INSERT, 32'hFFFF_FFFF);

        // Drain everything in order and run once more into underflow.
        repeat (7) issue_command(KIND_REMOVE, 32'hFFFF_FFFF);

        // Hold off until the queue has answered every command so far.
        drain_queue();

        random_phase(470, 28);
        drain_queue();
        random_phase(470, 81);
        drain_queue();
        random_phase(470, 0);
        drain_queue();

        // Allow for any stray result beat after the last expected one.
        repeat (4) @(posedge clk);

        if (failures == 0)
            $display("sorted_max_priority_queue verification clean");
        else
            $display("sorted_max_priority_queue verification failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_max_priority_queue.sv
tb/sv/spq_outcome_checker.sv
tb/sv/tb.sv
